// ----- hw/rtl/bcdcc_pkg.sv -----
// Shared types, codes, reset values and BCD helpers for the clock and calendar core.
package bcdcc_pkg;

   // Request kinds carried on req_tuser
   localparam logic REQ_TICK = 1'b0;
   localparam logic REQ_LOAD = 1'b1;

   typedef struct packed {
      logic [5:0]  hour;
      logic [6:0]  minute;
      logic [6:0]  second;
      logic [5:0]  day;
      logic [4:0]  month;
      logic [15:0] year;
      logic [2:0]  weekday;
   } cal_type;

   localparam cal_type CAL_RESET = '{
      hour:    6'h12,
      minute:  7'h30,
      second:  7'h30,
      day:     6'h07,
      month:   5'h07,
      year:    16'h2013,
      weekday: 3'd6
   };

   localparam logic [2:0] WEEKDAY_LAST = 3'd6;
   localparam logic [7:0] MONTHS_PER_YEAR = 8'd12;

   // Two-digit packed BCD increment; a low digit of 9 or more carries
   function automatic logic [7:0] bcd_inc(input logic [7:0] v);
      logic [3:0] lo;
      logic [3:0] hi;
      lo = v[3:0];
      hi = v[7:4];
      if (lo >= 4'd9) begin
         lo = 4'd0;
         hi = hi + 4'd1;
      end else begin
         lo = lo + 4'd1;
      end
      return {hi, lo};
   endfunction

   // Binary value of two raw nibbles: tens * 10 + units
   function automatic logic [7:0] bcd_val(input logic [7:0] v);
      return 8'({v[7:4], 3'b000}) + 8'({v[7:4], 1'b0}) + 8'(v[3:0]);
   endfunction

   // Gregorian leap test on the raw nibbles. 1000 and 100 are multiples of 4,
   // so only the low two digits matter off-century; on a century the count of
   // hundreds mod 4 is 2*d3 + d2 (+1 when the low pair reads as 100).
   function automatic logic is_leap(input logic [15:0] y);
      logic [7:0] low;
      logic       low_hundred;
      logic [1:0] cent_mod;
      low         = bcd_val(y[7:0]);
      low_hundred = (low == 8'd100);
      cent_mod    = {y[12], 1'b0} + y[9:8] + {1'b0, low_hundred};
      if ((low == 8'd0) || low_hundred) begin
         return (cent_mod == 2'd0);
      end
      return (low[1:0] == 2'd0);
   endfunction

   function automatic logic [4:0] month_len(input logic [4:0] m, input logic [15:0] y);
      if ((m == 5'h04) || (m == 5'h06) || (m == 5'h09) || (m == 5'h11)) begin
         return 5'd30;
      end
      if (m == 5'h02) begin
         return is_leap(y) ? 5'd29 : 5'd28;
      end
      return 5'd31;
   endfunction

   // Four-digit BCD year increment, 9999 wraps to 0000
   function automatic logic [15:0] year_inc(input logic [15:0] y);
      logic [15:0] r;
      logic        carry;
      logic [3:0]  d;
      r     = '0;
      carry = 1'b1;
      for (int k = 0; k < 4; k++) begin
         d = y[4*k +: 4];
         if (carry) begin
            if (d >= 4'd9) begin
               d = 4'd0;
            end else begin
               d     = d + 4'd1;
               carry = 1'b0;
            end
         end
         r[4*k +: 4] = d;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/bcdcc_update.sv -----
// Next-state logic: one second tick with carries through the date, or a load.
module bcdcc_update (
   input  logic              req_kind,
   input  bcdcc_pkg::cal_type cur,
   input  bcdcc_pkg::cal_type load,
   output bcdcc_pkg::cal_type nxt,
   output logic              new_day
);

   logic [7:0] day_val;
   logic [7:0] month_val;
   logic [4:0] mlen;

   assign day_val   = bcdcc_pkg::bcd_val({2'b00, cur.day});
   assign month_val = bcdcc_pkg::bcd_val({3'b000, cur.month});
   assign mlen      = bcdcc_pkg::month_len(cur.month, cur.year);

   always_comb begin
      nxt     = cur;
      new_day = 1'b0;
      if (req_kind == bcdcc_pkg::REQ_LOAD) begin
         nxt = load;
      end else if (cur.second < 7'h59) begin
         nxt.second = 7'(bcdcc_pkg::bcd_inc({1'b0, cur.second}));
      end else begin
         nxt.second = '0;
         if (cur.minute < 7'h59) begin
            nxt.minute = 7'(bcdcc_pkg::bcd_inc({1'b0, cur.minute}));
         end else begin
            nxt.minute = '0;
            if (cur.hour < 6'h23) begin
               nxt.hour = 6'(bcdcc_pkg::bcd_inc({2'b00, cur.hour}));
            end else begin
               // midnight: advance the date
               nxt.hour    = '0;
               new_day     = 1'b1;
               nxt.weekday = (cur.weekday >= bcdcc_pkg::WEEKDAY_LAST) ? 3'd0
                                                                      : cur.weekday + 3'd1;
               if (day_val >= {3'b000, mlen}) begin
                  nxt.day = 6'h01;
                  if (month_val >= bcdcc_pkg::MONTHS_PER_YEAR) begin
                     nxt.month = 5'h01;
                     nxt.year  = bcdcc_pkg::year_inc(cur.year);
                  end else begin
                     nxt.month = 5'(bcdcc_pkg::bcd_inc({3'b000, cur.month}));
                  end
               end else begin
                  nxt.day = 6'(bcdcc_pkg::bcd_inc({2'b00, cur.day}));
               end
            end
         end
      end
   end

endmodule

// ----- hw/rtl/bcd_clock_calendar_core.sv -----
// BCD real-time clock and calendar core: stream top level with state and output registers.
// Each request beat is a one-second tick (req_tuser 0) or a load of time and date
// (req_tuser 1); every beat yields exactly one response beat holding the time and date
// after the update, with rsp_tuser set when that tick crossed midnight. One beat is
// taken per clock while req_tready is high. The accepting edge fills the input register;
// once the output register is free, the update writes the calendar state and the output
// register together, and the result is then offered on rsp. The calendar state loop
// closes through the combinational update logic. A stalled output holds one result and
// one more request waits in the input register before req_tready drops. Loaded values
// are stored unchecked. Reset restores 12:30:30, 2013-07-07, weekday 6.
module bcd_clock_calendar_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [5:0] set_hour, [12:6] set_minute, [19:13] set_second, [25:20] set_day,
   // [30:26] set_month, [46:31] set_year, [49:47] set_weekday, [55:50] zero
   input  logic [55:0] req_tdata,
   // [0] req_type
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [5:0] hour, [12:6] minute, [19:13] second, [25:20] day_of_month,
   // [30:26] month_now, [46:31] year_now, [49:47] weekday, [55:50] zero
   output logic [55:0] rsp_tdata,
   // [0] new_day
   output logic        rsp_tuser
);

   // input register
   logic               in_valid_ff, in_valid_in;
   logic               in_kind_ff;
   bcdcc_pkg::cal_type in_load_ff;

   // calendar state
   bcdcc_pkg::cal_type cal_ff, cal_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   bcdcc_pkg::cal_type out_cal_ff;
   logic               out_new_day_ff;

   bcdcc_pkg::cal_type req_load;
   logic               new_day;
   logic               out_free;
   logic               step;

   assign req_load.hour    = req_tdata[5:0];
   assign req_load.minute  = req_tdata[12:6];
   assign req_load.second  = req_tdata[19:13];
   assign req_load.day     = req_tdata[25:20];
   assign req_load.month   = req_tdata[30:26];
   assign req_load.year    = req_tdata[46:31];
   assign req_load.weekday = req_tdata[49:47];

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   bcdcc_update u_update (
      .req_kind (in_kind_ff),
      .cur      (cal_ff),
      .load     (in_load_ff),
      .nxt      (cal_in),
      .new_day  (new_day)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         cal_ff       <= bcdcc_pkg::CAL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            cal_ff <= cal_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff <= req_tuser;
         in_load_ff <= req_load;
      end
      if (step) begin
         out_cal_ff     <= cal_in;
         out_new_day_ff <= new_day;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_new_day_ff;
   assign rsp_tdata  = {6'b000000, out_cal_ff.weekday, out_cal_ff.year, out_cal_ff.month,
                        out_cal_ff.day, out_cal_ff.second, out_cal_ff.minute,
                        out_cal_ff.hour};

   // a midnight crossing always shows 00:00:00
   a_new_day_midnight: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |->
         (rsp_tdata[5:0] == 6'h00 && rsp_tdata[12:6] == 7'h00 && rsp_tdata[19:13] == 7'h00))
      else $error("new_day beat without 00:00:00");

   // the shown beat matches the calendar state just written
   a_out_tracks_state: assert property (@(posedge clock) disable iff (reset)
      step |=> (out_cal_ff == cal_ff))
      else $error("output register and calendar state disagree");

   // a load never reports a new day
   a_load_no_new_day: assert property (@(posedge clock) disable iff (reset)
      (step && in_kind_ff == bcdcc_pkg::REQ_LOAD) |=> !rsp_tuser)
      else $error("load beat flagged new_day");

   // weekday after a midnight roll is always in 0..6
   a_weekday_wrap: assert property (@(posedge clock) disable iff (reset)
      (step && new_day) |=> (cal_ff.weekday <= bcdcc_pkg::WEEKDAY_LAST))
      else $error("weekday out of range after midnight");

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the BCD clock and calendar core: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_top;

   localparam int HOLD_CYCLES = 300;

   typedef struct {
      bcdcc_pkg::cal_type cal;
      logic               new_day;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   bcdcc_pkg::cal_type cal_now = bcdcc_pkg::CAL_RESET;
   reading_type        pending_readings[$];

   int tx_gap_pct = 0;
   int rx_stall_pct = 0;
   int hold_asked = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int fail_count = 0;
   int beats_checked = 0;
   int loads_sent = 0;
   int ticks_sent = 0;
   int midnights = 0;

   bcd_clock_calendar_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   initial begin
      #400000;
      $display("tb_top: FAIL");
      $finish;
   end

   // ---------------- calendar predictor ----------------

   function automatic int pair_inc(int v);
      int lo;
      int hi;
      lo = v & 15;
      hi = (v >> 4) & 15;
      if (lo >= 9) begin
         lo = 0;
         hi = hi + 1;
      end else begin
         lo = lo + 1;
      end
      return (hi << 4) | lo;
   endfunction

   function automatic int pair_value(int v);
      return ((v >> 4) & 15) * 10 + (v & 15);
   endfunction

   function automatic bit has_feb29(int y);
      int n;
      n = ((y >> 12) & 15) * 1000 + ((y >> 8) & 15) * 100 + ((y >> 4) & 15) * 10 + (y & 15);
      if (n % 100 == 0) return (n % 400 == 0);
      return (n % 4 == 0);
   endfunction

   function automatic int days_in_month(int m, int y);
      if (m == 'h04 || m == 'h06 || m == 'h09 || m == 'h11) return 30;
      if (m == 'h02) return has_feb29(y) ? 29 : 28;
      return 31;
   endfunction

   function automatic int year_inc4(int y);
      int r;
      int d;
      bit carry;
      r = 0;
      carry = 1'b1;
      for (int k = 0; k < 4; k++) begin
         d = (y >> (4 * k)) & 15;
         if (carry) begin
            if (d >= 9) begin
               d = 0;
            end else begin
               d = d + 1;
               carry = 1'b0;
            end
         end
         r = r | (d << (4 * k));
      end
      return r & 'hFFFF;
   endfunction

   task automatic advance_calendar(input logic kind, input bcdcc_pkg::cal_type load,
                                   output reading_type res);
      logic midnight;
      midnight = 1'b0;
      if (kind == bcdcc_pkg::REQ_LOAD) begin
         cal_now = load;
      end else if (cal_now.second < 7'h59) begin
         cal_now.second = 7'(pair_inc(cal_now.second));
      end else begin
         cal_now.second = '0;
         if (cal_now.minute < 7'h59) begin
            cal_now.minute = 7'(pair_inc(cal_now.minute));
         end else begin
            cal_now.minute = '0;
            if (cal_now.hour < 6'h23) begin
               cal_now.hour = 6'(pair_inc(cal_now.hour));
            end else begin
               cal_now.hour = '0;
               midnight = 1'b1;
               midnights++;
               cal_now.weekday = (cal_now.weekday >= bcdcc_pkg::WEEKDAY_LAST) ? 3'd0
                                                                  : cal_now.weekday + 3'd1;
               if (pair_value(cal_now.day) >= days_in_month(cal_now.month, cal_now.year)) begin
                  cal_now.day = 6'h01;
                  if (pair_value(cal_now.month) >= 12) begin
                     cal_now.month = 5'h01;
                     cal_now.year = 16'(year_inc4(cal_now.year));
                  end else begin
                     cal_now.month = 5'(pair_inc(cal_now.month));
                  end
               end else begin
                  cal_now.day = 6'(pair_inc(cal_now.day));
               end
            end
         end
      end
      res.cal = cal_now;
      res.new_day = midnight;
   endtask

   // ---------------- beat packing and stimulus helpers ----------------

   function automatic logic [55:0] pack_fields(bcdcc_pkg::cal_type c);
      return {6'd0, c.weekday, c.year, c.month, c.day, c.second, c.minute, c.hour};
   endfunction

   function automatic int to_bcd2(int v);
      return ((v / 10) << 4) | (v % 10);
   endfunction

   function automatic bcdcc_pkg::cal_type stamp(int h, int mi, int s, int d, int mo, int y,
                                                int w);
      bcdcc_pkg::cal_type c;
      c.hour    = 6'(h);
      c.minute  = 7'(mi);
      c.second  = 7'(s);
      c.day     = 6'(d);
      c.month   = 5'(mo);
      c.year    = 16'(y);
      c.weekday = 3'(w);
      return c;
   endfunction

   // raw values over part of each field's range, bad BCD digits included
   function automatic bcdcc_pkg::cal_type random_fields();
      return stamp($urandom_range(35), $urandom_range(89), $urandom_range(89),
                   $urandom_range(49), $urandom_range(18), $urandom_range(16'h9999),
                   $urandom_range(6));
   endfunction

   // valid time, usually just before midnight, often at a month end
   function automatic bcdcc_pkg::cal_type near_midnight();
      bcdcc_pkg::cal_type c;
      int m;
      int yv;
      int len;
      c.hour   = ($urandom_range(9) != 0) ? 6'h23 : 6'(to_bcd2($urandom_range(23)));
      c.minute = ($urandom_range(6) != 0) ? 7'h59 : 7'(to_bcd2($urandom_range(59)));
      c.second = 7'(to_bcd2($urandom_range(59, 48)));
      yv = $urandom_range(9999);
      if ($urandom_range(3) == 0) yv = yv - yv % 100;
      c.year = 16'((to_bcd2(yv / 100) << 8) | to_bcd2(yv % 100));
      m = ($urandom_range(3) == 0) ? 2 : $urandom_range(12, 1);
      c.month = 5'(to_bcd2(m));
      len = days_in_month(c.month, c.year);
      c.day = 6'(to_bcd2(($urandom_range(2) != 0) ? len - $urandom_range(1)
                                                  : $urandom_range(31, 1)));
      c.weekday = 3'($urandom_range(6));
      return c;
   endfunction

   // called at a falling edge, returns at a falling edge
   task automatic send_beat(input logic kind, input bcdcc_pkg::cal_type c);
      reading_type want;
      while ($urandom_range(99) < tx_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= pack_fields(c);
      do @(posedge clock); while (!req_tready);
      advance_calendar(kind, c, want);
      pending_readings.push_back(want);
      if (kind == bcdcc_pkg::REQ_LOAD) loads_sent++;
      else ticks_sent++;
      @(negedge clock);
   endtask

   // tick beats carry random data that the core must ignore
   task automatic send_tick();
      send_beat(bcdcc_pkg::REQ_TICK, random_fields());
   endtask

   task automatic load_and_tick(input bcdcc_pkg::cal_type c, input int n);
      send_beat(bcdcc_pkg::REQ_LOAD, c);
      repeat (n) send_tick();
   endtask

   task automatic wait_all_done();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // ---------------- receiver and checker ----------------

   always @(negedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   task automatic check_field(input string name, input int unsigned want_v,
                              input int unsigned got_v);
      if (want_v != got_v) begin
         $error("%s: expected %0h, got %0h", name, want_v, got_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_readings
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("response beat with no request pending");
            fail_count++;
         end else begin
            want = pending_readings.pop_front();
            beats_checked++;
            check_field("hour", want.cal.hour, rsp_tdata[5:0]);
            check_field("minute", want.cal.minute, rsp_tdata[12:6]);
            check_field("second", want.cal.second, rsp_tdata[19:13]);
            check_field("day_of_month", want.cal.day, rsp_tdata[25:20]);
            check_field("month_now", want.cal.month, rsp_tdata[30:26]);
            check_field("year_now", want.cal.year, rsp_tdata[46:31]);
            check_field("weekday", want.cal.weekday, rsp_tdata[49:47]);
            check_field("pad", 0, rsp_tdata[55:50]);
            check_field("new_day", want.new_day, rsp_tuser);
         end
      end
   end

   // ---------------- tests ----------------

   task automatic test_reset_and_carries();
      send_tick();
      load_and_tick(stamp('h09, 'h59, 'h59, 'h15, 'h03, 'h2021, 2), 1);
      load_and_tick(stamp('h23, 'h59, 'h58, 'h31, 'h12, 'h2013, 6), 2);
      wait_all_done();
   endtask

   task automatic test_month_and_year_ends();
      load_and_tick(stamp('h23, 'h59, 'h59, 'h29, 'h02, 'h2000, 2), 1);
      load_and_tick(stamp('h23, 'h59, 'h59, 'h28, 'h02, 'h1900, 3), 1);
      load_and_tick(stamp('h23, 'h59, 'h59, 'h28, 'h02, 'h2024, 4), 1);
      load_and_tick(stamp('h23, 'h59, 'h59, 'h31, 'h12, 'h9999, 5), 1);
      load_and_tick(stamp('h23, 'h59, 'h59, 'h30, 'h04, 'h2024, 1), 1);
      wait_all_done();
   endtask

   task automatic test_unchecked_loads();
      // bad digits in many fields, weekday 7
      load_and_tick(stamp('h1F, 'h4F, 'h3C, 'h00, 'h00, 'h19F9, 7), 1);
      load_and_tick(stamp('h1A, 'h4F, 'h59, 'h2C, 'h12, 'h0000, 0), 1);
      // day 00 and month 00 at midnight, weekday 7 wraps
      load_and_tick(stamp('h23, 'h59, 'h59, 'h00, 'h00, 'h1F9A, 7), 1);
      // month past 12 wraps, year carries through a bad digit
      load_and_tick(stamp('h23, 'h59, 'h59, 'h31, 'h0F, 'h19F9, 0), 1);
      wait_all_done();
   endtask

   task automatic test_random_traffic(input int gap_pct, input int stall_pct, input int n_items);
      int sent;
      int r;
      int ticks;
      tx_gap_pct   = gap_pct;
      rx_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         r = $urandom_range(99);
         if (r < 70) begin
            send_beat(bcdcc_pkg::REQ_LOAD, near_midnight());
            ticks = $urandom_range(12, 1);
            sent++;
         end else if (r < 85) begin
            send_beat(bcdcc_pkg::REQ_LOAD, random_fields());
            ticks = $urandom_range(6);
            sent++;
         end else begin
            ticks = $urandom_range(20, 1);
         end
         repeat (ticks) send_tick();
         sent += ticks;
      end
      wait_all_done();
   endtask

   // receiver holds off while the sender keeps offering, so the core backs up
   task automatic test_output_backpressure();
      tx_gap_pct   = 0;
      rx_stall_pct = 0;
      hold_asked++;
      load_and_tick(near_midnight(), 39);
      wait_all_done();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_and_carries();
      test_month_and_year_ends();
      test_unchecked_loads();
      test_random_traffic(0, 0, 450);
      test_random_traffic(57, 0, 450);
      test_random_traffic(0, 57, 450);
      test_random_traffic(32, 32, 450);
      test_output_backpressure();

      if (pending_readings.size() != 0) begin
         $error("%0d expected readings never arrived", pending_readings.size());
         fail_count++;
      end
      $display("Summary: %0d response beats checked from %0d loads and %0d ticks,",
               beats_checked, loads_sent, ticks_sent);
      $display("Summary: %0d midnight rollovers, idle and stall mixes plus a long output hold",
               midnights);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
